// ===== sv/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants of the bitmap set engine
// Word layout, operation codes, channel payloads, store request and the
// constant masks that the word unit uses for its bit scans.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  // Geometry of the set
  localparam int CAPACITY  = 1024;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = CAPACITY / WORD_BITS;   // must not exceed WORD_BITS
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = $clog2(NWORDS);
  localparam int PC_W      = BIT_W + 1;

  // Fixed field widths of the channels
  localparam int MODE_W    = 4;
  localparam int ELEM_W    = 10;
  localparam int WSEL_W    = 5;
  localparam int OPND_W    = 32;
  localparam int CNT_W     = 11;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_REMOVE = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_TEST   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_LOWEST = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_COUNT  = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_OR     = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_AND    = MODE_W'(7);
  localparam logic [MODE_W-1:0] MODE_XOR    = MODE_W'(8);
  localparam logic [MODE_W-1:0] MODE_ANDN   = MODE_W'(9);
  localparam logic [MODE_W-1:0] MODE_SUBSET = MODE_W'(10);
  localparam logic [MODE_W-1:0] MODE_READ   = MODE_W'(11);

  // Logic function of the word unit
  typedef enum logic [1:0] {
    FN_OR   = 2'd0,
    FN_AND  = 2'd1,
    FN_XOR  = 2'd2,
    FN_ANDN = 2'd3
  } fn_t;

  // Input word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ELEM_W-1:0] elem_index;
    logic [WSEL_W-1:0] word_index;
    logic [OPND_W-1:0] operand_word;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              is_member;
    logic              found;
    logic [ELEM_W-1:0] lowest_member;
    logic [CNT_W-1:0]  member_count;
    logic [OPND_W-1:0] word_out;
  } out_word_t;

  // Request from the sequencer to the bitmap store
  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic                 clr;
    logic [WIDX_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } store_req_t;

  // Bits whose index has bit lvl clear: pairs the fields of a SWAR popcount
  function automatic logic [WORD_BITS-1:0] alt_mask(input int lvl);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (((i >> lvl) & 1) == 0);
    end
    return m;
  endfunction

  // Lowest 2**lvl bits set
  function automatic logic [WORD_BITS-1:0] low_mask(input int lvl);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (i < (1 << lvl));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bse_word_unit.sv =====
// ----------------------------------------------------------------------------
// bse_word_unit: shared word unit
// One word in, one operand in: logic result, population count and index of
// the lowest set bit. Reused by the find, update and recount steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_word_unit
  import bse_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] a,
  input  wire logic [WORD_BITS-1:0] b,
  input  wire fn_t                  fn,
  output logic      [WORD_BITS-1:0] res,
  output logic      [PC_W-1:0]      pop,
  output logic      [BIT_W-1:0]     ctz
);

  logic [WORD_BITS-1:0] pc_v;
  logic [WORD_BITS-1:0] sc_v;

  // Logic function
  always_comb begin
    case (fn)
      FN_OR:   res = a | b;
      FN_AND:  res = a & b;
      FN_XOR:  res = a ^ b;
      FN_ANDN: res = a & ~b;
      default: res = a & b;
    endcase
  end

  // Popcount: log2 levels of pairwise field adds
  always_comb begin
    pc_v = a;
    for (int l = 0; l < BIT_W; l++) begin
      pc_v = (pc_v & alt_mask(l)) + ((pc_v >> (1 << l)) & alt_mask(l));
    end
    pop = pc_v[PC_W-1:0];
  end

  // Lowest set bit: binary search, one index bit per level (all ones for zero)
  always_comb begin
    sc_v = a;
    ctz  = '0;
    for (int l = BIT_W - 1; l >= 0; l--) begin
      if ((sc_v & low_mask(l)) == '0) begin
        ctz[l] = 1'b1;
        sc_v   = sc_v >> (1 << l);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bse_store.sv =====
// ----------------------------------------------------------------------------
// bse_store: bitmap word store
// Single-port word memory with registered read, a valid bit per word so that
// clear is immediate, and a nonzero flag per word for lowest-member search.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_store
  import bse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire store_req_t           req,
  output logic      [WORD_BITS-1:0] rd_data,
  output logic      [NWORDS-1:0]    nz
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    word_valid;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_valid;

  // Memory array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q     <= mem[req.addr];
      rd_valid <= word_valid[req.addr];
    end
  end

  // Valid and nonzero flags
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      word_valid <= '0;
      nz         <= '0;
    end else if (req.wr_en) begin
      word_valid[req.addr] <= 1'b1;
      nz[req.addr]         <= |req.wdata;
    end
  end

  // A word never written since clear reads as zero
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

// ===== sv/bitmap_set_engine.sv =====
// ----------------------------------------------------------------------------
// bitmap_set_engine: bitmap set of the integers 0..1023
// Insert, remove, test, clear, lowest member, count and word-wise set ops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one operation word;
//   output channel (out_valid / out_stall / out_data) returns one result word
//   for every operation. in_stall is high from acceptance until the result
//   has been loaded into the output register.
//   Steps from acceptance to loading the result:
//     read-modify-write modes (insert, remove, OR, AND, XOR, AND-NOT):
//     read, calculate, recount; test, subset, read word: read, calculate;
//     lowest member: find, read, calculate (find only if the set is empty);
//     clear, count, undefined modes: none.
//   A new word is taken the cycle after the result loads, not earlier, since
//   the single-port store and one word unit go through read, update, recount.
//   Reset empties the set at once (per-word valid bits) and drops any
//   pending result. While the receiver stalls, the result is held and the
//   next operation waits in its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_set_engine
  import bse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_READ  = 6'b000100,
    S_CALC  = 6'b001000,
    S_COUNT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state, state_next;
  in_word_t             item;
  logic [WIDX_W-1:0]    waddr;
  logic [CNT_W-1:0]     running_count;
  logic [WORD_BITS-1:0] new_word;
  logic [PC_W-1:0]      pc_old;
  logic                 is_member_q;
  logic                 found_q;
  logic [ELEM_W-1:0]    lowest_q;
  logic [WORD_BITS-1:0] word_q;

  logic                 in_acc;
  logic                 elem_ok;
  logic                 widx_ok;
  logic                 out_free;
  logic                 is_write;
  store_req_t           sreq;
  logic [WORD_BITS-1:0] rd_data;
  logic [NWORDS-1:0]    nz;
  logic [WORD_BITS-1:0] ua, ub, ures;
  fn_t                  ufn;
  logic [PC_W-1:0]      upop;
  logic [BIT_W-1:0]     uctz;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign elem_ok  = ({1'b0, in_data.elem_index} < (ELEM_W + 1)'(CAPACITY));
  assign widx_ok  = ({1'b0, in_data.word_index} < (WSEL_W + 1)'(NWORDS));

  always_comb begin
    is_write = 1'b0;
    case (item.mode) inside
      MODE_INSERT, MODE_REMOVE, MODE_OR, MODE_AND, MODE_XOR, MODE_ANDN: is_write = 1'b1;
      default: is_write = 1'b0;
    endcase
  end

  // Word unit operand selection
  always_comb begin
    case (state)
      S_FIND:  ua = WORD_BITS'(nz);
      S_COUNT: ua = new_word;
      default: ua = rd_data;
    endcase
    case (item.mode) inside
      MODE_INSERT, MODE_REMOVE, MODE_TEST:
        ub = WORD_BITS'(1) << item.elem_index[BIT_W-1:0];
      default:
        ub = WORD_BITS'(item.operand_word);
    endcase
    case (item.mode) inside
      MODE_INSERT, MODE_OR:  ufn = FN_OR;
      MODE_REMOVE, MODE_ANDN: ufn = FN_ANDN;
      MODE_XOR:               ufn = FN_XOR;
      default:                ufn = FN_AND;
    endcase
  end

  bse_word_unit u_unit (
    .a   (ua),
    .b   (ub),
    .fn  (ufn),
    .res (ures),
    .pop (upop),
    .ctz (uctz)
  );

  // Store requests
  always_comb begin
    sreq.rd_en = (state == S_READ);
    sreq.wr_en = (state == S_CALC) && is_write;
    sreq.clr   = in_acc && (in_data.mode == MODE_CLEAR);
    sreq.addr  = waddr;
    sreq.wdata = ures;
  end

  bse_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .rd_data (rd_data),
    .nz      (nz)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.mode) inside
            MODE_INSERT, MODE_REMOVE, MODE_TEST:
              state_next = elem_ok ? S_READ : S_DONE;
            MODE_LOWEST:
              state_next = S_FIND;
            [MODE_OR:MODE_READ]:
              state_next = widx_ok ? S_READ : S_DONE;
            default:
              state_next = S_DONE;
          endcase
        end
      end
      S_FIND:  state_next = (nz == '0) ? S_DONE : S_READ;
      S_READ:  state_next = S_CALC;
      S_CALC:  state_next = is_write ? S_COUNT : S_DONE;
      S_COUNT: state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running member count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
    end else if (sreq.clr) begin
      running_count <= '0;
    end else if (state == S_COUNT) begin
      running_count <= running_count - CNT_W'(pc_old) + CNT_W'(upop);
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          item        <= in_data;
          is_member_q <= 1'b0;
          found_q     <= 1'b0;
          lowest_q    <= '0;
          word_q      <= '0;
          if (in_data.mode == MODE_INSERT || in_data.mode == MODE_REMOVE ||
              in_data.mode == MODE_TEST) begin
            waddr <= WIDX_W'(in_data.elem_index >> BIT_W);
          end else begin
            waddr <= WIDX_W'(in_data.word_index);
          end
        end
      end
      S_FIND: begin
        if (nz != '0) begin
          waddr   <= WIDX_W'(uctz);
          found_q <= 1'b1;
        end
      end
      S_CALC: begin
        new_word <= ures;
        pc_old   <= upop;
        case (item.mode) inside
          MODE_TEST: begin
            is_member_q <= (ures != '0);
            word_q      <= rd_data;
          end
          MODE_SUBSET: begin
            is_member_q <= (ures == ub);
            word_q      <= rd_data;
          end
          MODE_LOWEST: begin
            lowest_q <= ELEM_W'({waddr, uctz});
            word_q   <= rd_data;
          end
          MODE_READ: word_q <= rd_data;
          default:   word_q <= ures;
        endcase
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.is_member     <= is_member_q;
      out_data.found         <= found_q;
      out_data.lowest_member <= lowest_q;
      out_data.member_count  <= running_count;
      out_data.word_out      <= OPND_W'(word_q);
    end
  end

endmodule

`default_nettype wire

// ===== sv/bse_checker.sv =====
// ----------------------------------------------------------------------------
// bse_checker: port-level checks of the bitmap set engine
// Watches both channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_checker
  import bse_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // One operation at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an operation is in flight");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Reported lowest member is present in the reported word
  a_lowest_in_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      out_data.word_out[out_data.lowest_member[BIT_W-1:0]])
    else $error("lowest member bit not set in its word");

  // A found member means a nonempty set
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.member_count != '0)
    else $error("member found in an empty set");

  // Count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.member_count <= CNT_W'(CAPACITY))
    else $error("member count above capacity");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bitmap set engine
// A queue-fed driver offers operation words in bursts and a monitor mirrors
// every accepted word into a software copy of the set. Each result word is
// compared field by field with the oldest predicted one. The receiver stalls
// on its own pattern, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------

module testbench;
  import bse_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int LONG_HOLD  = 300;    // receiver hold-off length
  localparam int HOLD_AT    = 250;    // input words taken before that hold-off
  localparam int N_ITEMS    = 700;

  typedef struct {
    in_word_t word;
    bit       drain;   // wait for all results before offering this word
  } pend_item_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  bitmap_set_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Software copy of the set
  logic [WORD_BITS-1:0] set_bits [NWORDS];
  logic [CNT_W-1:0]     set_count;

  pend_item_t pend [$];
  out_word_t  result_q [$];
  bit         drain_next;

  int  errors;
  int  inputs_taken;
  int  results_seen;
  int  idle_cycles;
  int  max_count;
  int  mode_hits [16];
  bit  in_taken;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  bit  hold_done;
  int  seg_left;
  int  seg_kind;

  // Write one word of the copy and keep the member count in step
  function automatic void store_word(int wsel, logic [WORD_BITS-1:0] nv);
    set_count = set_count - CNT_W'($countones(set_bits[wsel])) + CNT_W'($countones(nv));
    set_bits[wsel] = nv;
  endfunction

  // Apply one operation word to the copy, return the result it must give.
  // Both index fields span their whole range, so no index is out of range.
  function automatic out_word_t set_apply(in_word_t w);
    out_word_t            r;
    logic [WORD_BITS-1:0] cur;
    logic [WORD_BITS-1:0] bit_m;
    logic [WORD_BITS-1:0] opnd;
    int                   wsel;
    int                   low_bit;
    r = '0;
    low_bit = 0;
    opnd = w.operand_word[WORD_BITS-1:0];
    case (w.mode)
      MODE_INSERT, MODE_REMOVE, MODE_TEST: begin
        wsel  = int'(w.elem_index) / WORD_BITS;
        bit_m = WORD_BITS'(1) << (int'(w.elem_index) % WORD_BITS);
        cur   = set_bits[wsel];
        if (w.mode == MODE_INSERT) begin
          store_word(wsel, cur | bit_m);
        end else if (w.mode == MODE_REMOVE) begin
          store_word(wsel, cur & ~bit_m);
        end else begin
          r.is_member = |(cur & bit_m);
        end
        r.word_out = set_bits[wsel];
      end
      MODE_CLEAR: begin
        foreach (set_bits[i]) set_bits[i] = '0;
        set_count = '0;
      end
      MODE_LOWEST: begin
        // scan down so the last hit is the lowest nonzero word
        for (int i = NWORDS - 1; i >= 0; i--) begin
          if (set_bits[i] != '0) begin
            r.found    = 1'b1;
            r.word_out = set_bits[i];
            for (int k = WORD_BITS - 1; k >= 0; k--) begin
              if (set_bits[i][k]) low_bit = k;
            end
            r.lowest_member = ELEM_W'(i * WORD_BITS + low_bit);
          end
        end
      end
      MODE_OR, MODE_AND, MODE_XOR, MODE_ANDN, MODE_SUBSET, MODE_READ: begin
        wsel = int'(w.word_index);
        cur  = set_bits[wsel];
        case (w.mode)
          MODE_OR:     store_word(wsel, cur | opnd);
          MODE_AND:    store_word(wsel, cur & opnd);
          MODE_XOR:    store_word(wsel, cur ^ opnd);
          MODE_ANDN:   store_word(wsel, cur & ~opnd);
          MODE_SUBSET: r.is_member = ((cur & opnd) == opnd);
          default: ;
        endcase
        r.word_out = set_bits[wsel];
      end
      default: ;   // count and undefined modes change nothing
    endcase
    r.member_count = set_count;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
      errors++;
    end
  endtask

  // ---- stimulus building ----
  function automatic in_word_t rand_word(logic [MODE_W-1:0] m);
    in_word_t w;
    w.mode         = m;
    w.elem_index   = ELEM_W'($urandom);
    w.word_index   = WSEL_W'($urandom);
    w.operand_word = $urandom;
    return w;
  endfunction

  task automatic queue_word(in_word_t w);
    pend_item_t p;
    p.word  = w;
    p.drain = drain_next;
    drain_next = 1'b0;
    pend.push_back(p);
  endtask

  task automatic queue_elem(logic [MODE_W-1:0] m, int e);
    in_word_t w;
    w = rand_word(m);
    w.elem_index = ELEM_W'(e);
    queue_word(w);
  endtask

  task automatic queue_wordop(logic [MODE_W-1:0] m, int wi, logic [31:0] op);
    in_word_t w;
    w = rand_word(m);
    w.word_index   = WSEL_W'(wi);
    w.operand_word = op;
    queue_word(w);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---- driver: bursts of words with random gaps ----
  always @(negedge clk) begin : drive
    pend_item_t nxt;
    logic       offer;
    if (!rst && !(in_valid && !in_taken)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend.size() > 0 && !(pend[0].drain && result_q.size() > 0)) begin
        nxt = pend.pop_front();
        in_data <= nxt.word;
        offer = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_valid <= offer;
    end
  end

  // ---- receiver: stall pattern in segments, one long hold-off ----
  always @(negedge clk) begin : recv
    logic s;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && inputs_taken >= HOLD_AT) begin
      hold_left = LONG_HOLD - 1;
      hold_done = 1'b1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        seg_kind = $urandom_range(0, 3);
      end
      seg_left--;
      case (seg_kind)
        0:       s = 1'b0;
        1:       s = ($urandom_range(0, 3) == 0);
        2:       s = $urandom_range(0, 1);
        default: s = (seg_left % 3) != 0;
      endcase
      out_stall <= s;
    end
  end

  // ---- monitor: predict on input, check on output ----
  always @(posedge clk) begin : watch
    out_word_t want;
    in_taken = 1'b0;
    if (!rst) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        want = set_apply(in_data);
        result_q.push_back(want);
        inputs_taken++;
        mode_hits[in_data.mode]++;
        if (int'(want.member_count) > max_count) max_count = int'(want.member_count);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected, got %0h", $time, out_data);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("is_member",     32'(want.is_member),     32'(out_data.is_member));
          check_field("found",         32'(want.found),         32'(out_data.found));
          check_field("lowest_member", 32'(want.lowest_member), 32'(out_data.lowest_member));
          check_field("member_count",  32'(want.member_count),  32'(out_data.member_count));
          check_field("word_out",      want.word_out,           out_data.word_out);
        end
      end
      if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : main
    int  g;
    int  n;
    int  base;
    int  r;
    int  next_drain;
    bit  timed_out;
    in_word_t w;

    foreach (set_bits[i]) set_bits[i] = '0;
    set_count = '0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    // directed: field extremes, every mode, empty-set and undefined cases
    queue_elem(MODE_INSERT, 0);
    queue_elem(MODE_INSERT, 1023);
    queue_elem(MODE_TEST, 0);
    queue_elem(MODE_TEST, 1023);
    queue_elem(MODE_TEST, 512);
    queue_word(rand_word(MODE_LOWEST));
    queue_word(rand_word(MODE_COUNT));
    queue_elem(MODE_REMOVE, 0);
    queue_word(rand_word(MODE_LOWEST));
    queue_elem(MODE_REMOVE, 5);
    queue_wordop(MODE_READ, 31, $urandom);
    queue_wordop(MODE_OR, 3, 32'hFFFF_FFFF);
    queue_wordop(MODE_AND, 3, 32'hA5A5_A5A5);
    queue_wordop(MODE_XOR, 3, 32'hFFFF_FFFF);
    queue_wordop(MODE_ANDN, 3, 32'h0F0F_0F0F);
    queue_wordop(MODE_SUBSET, 3, 32'h0);
    queue_wordop(MODE_SUBSET, 31, 32'h8000_0000);
    queue_wordop(MODE_SUBSET, 31, 32'hFFFF_FFFF);
    queue_word(rand_word(MODE_W'(12)));
    queue_word(rand_word(MODE_W'(15)));
    queue_word(rand_word(MODE_COUNT));
    queue_word(rand_word(MODE_CLEAR));
    queue_word(rand_word(MODE_LOWEST));
    queue_elem(MODE_TEST, 1023);
    queue_wordop(MODE_READ, 0, 32'h0);

    // random: groups of related operations, some noise
    next_drain = 150;
    while (pend.size() < N_ITEMS) begin
      if (pend.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 250;
      end
      g = $urandom_range(0, 9);
      case (g)
        0, 1, 2: begin
          // element ops clustered in a few words so they collide
          base = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
          n = $urandom_range(3, 10);
          repeat (n) begin
            r = $urandom_range(0, 3);
            queue_elem((r <= 1) ? MODE_INSERT : (r == 2) ? MODE_REMOVE : MODE_TEST,
                       base * WORD_BITS + $urandom_range(0, 31));
          end
        end
        3, 4: begin
          n = $urandom_range(3, 8);
          repeat (n) begin
            queue_wordop(MODE_W'(MODE_OR + $urandom_range(0, 5)),
                         $urandom_range(0, 31), rand_operand());
          end
        end
        5: begin
          queue_word(rand_word(MODE_LOWEST));
          queue_word(rand_word(MODE_COUNT));
          queue_wordop(MODE_SUBSET, $urandom_range(0, 31), rand_operand());
          queue_wordop(MODE_READ, $urandom_range(0, 31), $urandom);
        end
        6: begin
          queue_word(rand_word(MODE_CLEAR));
          queue_word(rand_word(MODE_LOWEST));
          queue_elem(MODE_INSERT, $urandom_range(512, 1023));
          queue_elem(MODE_INSERT, $urandom_range(0, 1023));
          queue_word(rand_word(MODE_LOWEST));
        end
        7: begin
          if ($urandom_range(0, 3) == 0) begin
            // fill the whole set, then take it apart from the bottom
            for (int i = 0; i < NWORDS; i++) queue_wordop(MODE_OR, i, 32'hFFFF_FFFF);
            queue_word(rand_word(MODE_COUNT));
            queue_word(rand_word(MODE_LOWEST));
            queue_elem(MODE_REMOVE, 0);
            queue_elem(MODE_REMOVE, 1);
            queue_word(rand_word(MODE_LOWEST));
            queue_wordop(MODE_ANDN, 0, 32'hFFFF_FFFF);
            queue_word(rand_word(MODE_LOWEST));
          end else begin
            queue_word(rand_word(MODE_W'($urandom_range(0, 15))));
          end
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) queue_word(rand_word(MODE_W'($urandom_range(0, 15))));
        end
        default: begin
          queue_word(rand_word(MODE_CLEAR));
          queue_word(rand_word(MODE_LOWEST));
          w = rand_word(MODE_TEST);
          queue_word(w);
        end
      endcase
    end

    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(pend.size() == 0 && !in_valid && result_q.size() == 0)
           && idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    timed_out = (idle_cycles >= IDLE_LIMIT);
    if (!timed_out) repeat (12) @(posedge clk);
    if (result_q.size() != 0) errors++;

    $display("Run: %0d words in, %0d results, %0d errors, peak member count %0d",
             inputs_taken, results_seen, errors, max_count);
    $display("Run: %0d undefined-mode words, long receiver hold %s, timed out %0d",
             mode_hits[12] + mode_hits[13] + mode_hits[14] + mode_hits[15],
             hold_done ? "done" : "not reached", timed_out);
    if (!timed_out && errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bse_pkg.sv
sv/bse_word_unit.sv
sv/bse_store.sv
sv/bitmap_set_engine.sv
sv/bse_checker.sv
tb/sv/testbench.sv
